>>> sv/imuavg_pkg.sv
// ----------------------------------------------------------------------------
// imuavg_pkg
// Shared types and constants for the six-axis averaging decimator.
// ----------------------------------------------------------------------------
package imuavg_pkg;

   localparam int SAMPLE_W = 16;
   localparam int DIV_W    = 10;
   localparam int SUM_W    = SAMPLE_W + DIV_W;
   localparam int TIME_W   = 32;
   localparam int NUM_AXES = 6;
   localparam int AXIS_W   = $clog2(NUM_AXES);
   localparam int CNT_W    = $clog2(SUM_W + 1);

   localparam logic [AXIS_W-1:0] AXIS_GYRO_X  = AXIS_W'(0);
   localparam logic [AXIS_W-1:0] AXIS_GYRO_Y  = AXIS_W'(1);
   localparam logic [AXIS_W-1:0] AXIS_GYRO_Z  = AXIS_W'(2);
   localparam logic [AXIS_W-1:0] AXIS_ACCEL_X = AXIS_W'(3);
   localparam logic [AXIS_W-1:0] AXIS_ACCEL_Y = AXIS_W'(4);
   localparam logic [AXIS_W-1:0] AXIS_ACCEL_Z = AXIS_W'(5);
   localparam logic [AXIS_W-1:0] AXIS_LAST    = AXIS_ACCEL_Z;

   localparam logic [DIV_W-1:0] DIV_OFF  = DIV_W'(0);
   localparam logic [DIV_W-1:0] DIV_PASS = DIV_W'(1);

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic signed [SUM_W-1:0]    sum_type;

   typedef struct packed {
      sample_type              gyro_x;
      sample_type              gyro_y;
      sample_type              gyro_z;
      sample_type              accel_x;
      sample_type              accel_y;
      sample_type              accel_z;
      logic [TIME_W-1:0]       sample_time;
   } req_type;

   typedef struct packed {
      sample_type              avg_gyro_x;
      sample_type              avg_gyro_y;
      sample_type              avg_gyro_z;
      sample_type              avg_accel_x;
      sample_type              avg_accel_y;
      sample_type              avg_accel_z;
      logic [TIME_W-1:0]       out_time;
   } rsp_type;

   typedef struct packed {
      logic                    en;
      logic                    fresh;
      logic [AXIS_W-1:0]       sel;
   } acc_ctrl_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ACCUM,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_OUT
   } state_type;

   function automatic sample_type axis_of(req_type r, logic [AXIS_W-1:0] idx);
      sample_type v;
      case (idx)
         AXIS_GYRO_X:  v = r.gyro_x;
         AXIS_GYRO_Y:  v = r.gyro_y;
         AXIS_GYRO_Z:  v = r.gyro_z;
         AXIS_ACCEL_X: v = r.accel_x;
         AXIS_ACCEL_Y: v = r.accel_y;
         AXIS_ACCEL_Z: v = r.accel_z;
         default:      v = r.gyro_x;
      endcase
      return v;
   endfunction

endpackage

>>> sv/imuavg_accum.sv
// ----------------------------------------------------------------------------
// imuavg_accum
// Per-axis running sums, one axis updated per cycle through a shared adder.
// ----------------------------------------------------------------------------
module imuavg_accum (
   input  logic                   clock,
   input  imuavg_pkg::acc_ctrl_type ctrl,
   input  imuavg_pkg::sample_type sample,
   output imuavg_pkg::sum_type    sum_out
);

   imuavg_pkg::sum_type sums_ff [imuavg_pkg::NUM_AXES];
   imuavg_pkg::sum_type sample_ext;
   imuavg_pkg::sum_type sum_in;

   assign sum_out    = sums_ff[ctrl.sel];
   assign sample_ext = imuavg_pkg::sum_type'(sample);

   // first sample of a group replaces the stale sum
   assign sum_in = ctrl.fresh ? sample_ext : sum_out + sample_ext;

   always_ff @(posedge clock) begin
      if (ctrl.en) begin
         sums_ff[ctrl.sel] <= sum_in;
      end
   end

endmodule

>>> sv/imuavg_divider.sv
// ----------------------------------------------------------------------------
// imuavg_divider
// Bit-serial restoring divider, signed dividend over unsigned divisor,
// one quotient bit per cycle, truncating toward zero.
// ----------------------------------------------------------------------------
module imuavg_divider (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  imuavg_pkg::sum_type            dividend,
   input  logic [imuavg_pkg::DIV_W-1:0]   divisor,
   output logic                           done,
   output imuavg_pkg::sample_type         quotient
);

   localparam int SUM_W = imuavg_pkg::SUM_W;
   localparam int DIV_W = imuavg_pkg::DIV_W;
   localparam int CNT_W = imuavg_pkg::CNT_W;

   logic                   busy_ff,  busy_in;
   logic                   done_ff,  done_in;
   logic [CNT_W-1:0]       cnt_ff,   cnt_in;
   logic [DIV_W-1:0]       rem_ff,   rem_in;
   logic [SUM_W-1:0]       quo_ff,   quo_in;
   logic [DIV_W-1:0]       dvs_ff,   dvs_in;
   logic                   neg_ff,   neg_in;
   imuavg_pkg::sample_type res_ff,   res_in;

   logic [SUM_W-1:0]       mag;
   logic [DIV_W:0]         trial;
   logic [DIV_W:0]         diff;
   logic                   ge;
   logic [SUM_W-1:0]       q_next;
   logic [SUM_W-1:0]       q_signed;

   assign mag    = dividend[SUM_W-1] ? (~dividend + SUM_W'(1)) : dividend;
   assign trial  = {rem_ff, quo_ff[SUM_W-1]};
   assign ge     = trial >= {1'b0, dvs_ff};
   assign diff   = trial - {1'b0, dvs_ff};
   assign q_next = {quo_ff[SUM_W-2:0], ge};
   assign q_signed = neg_ff ? (~q_next + SUM_W'(1)) : q_next;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      neg_in  = neg_ff;
      res_in  = res_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(SUM_W);
         rem_in  = '0;
         quo_in  = mag;
         dvs_in  = divisor;
         neg_in  = dividend[SUM_W-1];
      end else if (busy_ff) begin
         rem_in = ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
         quo_in = q_next;
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            res_in  = q_signed[imuavg_pkg::SAMPLE_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      neg_ff <= neg_in;
      res_ff <= res_in;
   end

   assign done     = done_ff;
   assign quotient = res_ff;

endmodule

>>> sv/imu_six_axis_averaging_decimator.sv
// ----------------------------------------------------------------------------
// imu_six_axis_averaging_decimator
// Boxcar averaging decimator for six-axis IMU samples.
// ----------------------------------------------------------------------------
// Input channel req_valid/req_ready/req_data carries one sample transaction:
// three gyro axes, three accel axes and a timestamp. Result channel
// rsp_valid/rsp_ready/rsp_data carries the averaged axes and the timestamp
// of the last sample of the group. csr_wr_en/csr_wr_data writes the divisor
// (write only while idle).
// Divisor 0: samples are taken and dropped, group count cleared.
// Divisor 1: each sample comes out unchanged, via the sample register and the output register.
// Divisor N > 1: a sample is summed into the six axis sums, one axis per
// cycle, and req_ready returns once all six are summed. The sample
// that closes a group then runs six divisions through one bit-serial
// divider, one axis after another, before the result is loaded.
// The divider's one bit per cycle sets the rate.
// The result sits in an output register; a stalled receiver does not stop
// intake of samples that leave a group open, but a new result, and with it intake, waits until the held one is taken.
// Reset (synchronous) clears the divisor to 0, the group count and all
// handshake state.
// ----------------------------------------------------------------------------
module imu_six_axis_averaging_decimator (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  imuavg_pkg::req_type           req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output imuavg_pkg::rsp_type           rsp_data,
   input  logic                          csr_wr_en,
   input  logic [imuavg_pkg::DIV_W-1:0]  csr_wr_data
);

   localparam int DIV_W  = imuavg_pkg::DIV_W;
   localparam int AXIS_W = imuavg_pkg::AXIS_W;

   imuavg_pkg::state_type  state_ff, state_in;
   logic [DIV_W-1:0]       div_ff;
   logic [DIV_W-1:0]       count_ff, count_in;
   logic                   fresh_ff, fresh_in;
   logic                   pass_ff,  pass_in;
   logic [AXIS_W-1:0]      axis_ff,  axis_in;
   imuavg_pkg::req_type    sample_ff;
   imuavg_pkg::sample_type avg_ff [imuavg_pkg::NUM_AXES];
   logic                   rsp_valid_ff, rsp_valid_in;
   imuavg_pkg::rsp_type    rsp_ff, rsp_in;

   imuavg_pkg::acc_ctrl_type acc_ctrl;
   imuavg_pkg::sum_type      sum_out;
   logic                     div_start;
   logic                     div_done;
   imuavg_pkg::sample_type   quotient;
   logic                     accept;
   logic                     out_free;

   imuavg_accum u_accum (
      .clock   (clock),
      .ctrl    (acc_ctrl),
      .sample  (imuavg_pkg::axis_of(sample_ff, axis_ff)),
      .sum_out (sum_out)
   );

   imuavg_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_out),
      .divisor  (count_ff),
      .done     (div_done),
      .quotient (quotient)
   );

   assign req_ready = (state_ff == imuavg_pkg::ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      fresh_in     = fresh_ff;
      pass_in      = pass_ff;
      axis_in      = axis_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      acc_ctrl     = '{en: 1'b0, fresh: fresh_ff, sel: axis_ff};
      div_start    = 1'b0;
      case (state_ff)
         imuavg_pkg::ST_IDLE: begin
            if (accept) begin
               if (div_ff == imuavg_pkg::DIV_OFF) begin
                  count_in = '0;
               end else if (div_ff == imuavg_pkg::DIV_PASS) begin
                  count_in = '0;
                  pass_in  = 1'b1;
                  state_in = imuavg_pkg::ST_OUT;
               end else begin
                  fresh_in = (count_ff == '0);
                  count_in = count_ff + DIV_W'(1);
                  pass_in  = 1'b0;
                  axis_in  = '0;
                  state_in = imuavg_pkg::ST_ACCUM;
               end
            end
         end
         imuavg_pkg::ST_ACCUM: begin
            acc_ctrl.en = 1'b1;
            if (axis_ff == imuavg_pkg::AXIS_LAST) begin
               axis_in = '0;
               // a lowered divisor also closes the group here
               state_in = (count_ff >= div_ff) ? imuavg_pkg::ST_DIV_START
                                                : imuavg_pkg::ST_IDLE;
            end else begin
               axis_in = axis_ff + AXIS_W'(1);
            end
         end
         imuavg_pkg::ST_DIV_START: begin
            div_start = 1'b1;
            state_in  = imuavg_pkg::ST_DIV_WAIT;
         end
         imuavg_pkg::ST_DIV_WAIT: begin
            if (div_done) begin
               if (axis_ff == imuavg_pkg::AXIS_LAST) begin
                  axis_in  = '0;
                  count_in = '0;
                  state_in = imuavg_pkg::ST_OUT;
               end else begin
                  axis_in  = axis_ff + AXIS_W'(1);
                  state_in = imuavg_pkg::ST_DIV_START;
               end
            end
         end
         imuavg_pkg::ST_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (pass_ff) begin
                  rsp_in = '{avg_gyro_x:  sample_ff.gyro_x,
                             avg_gyro_y:  sample_ff.gyro_y,
                             avg_gyro_z:  sample_ff.gyro_z,
                             avg_accel_x: sample_ff.accel_x,
                             avg_accel_y: sample_ff.accel_y,
                             avg_accel_z: sample_ff.accel_z,
                             out_time:    sample_ff.sample_time};
               end else begin
                  rsp_in = '{avg_gyro_x:  avg_ff[imuavg_pkg::AXIS_GYRO_X],
                             avg_gyro_y:  avg_ff[imuavg_pkg::AXIS_GYRO_Y],
                             avg_gyro_z:  avg_ff[imuavg_pkg::AXIS_GYRO_Z],
                             avg_accel_x: avg_ff[imuavg_pkg::AXIS_ACCEL_X],
                             avg_accel_y: avg_ff[imuavg_pkg::AXIS_ACCEL_Y],
                             avg_accel_z: avg_ff[imuavg_pkg::AXIS_ACCEL_Z],
                             out_time:    sample_ff.sample_time};
               end
               state_in = imuavg_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = imuavg_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= imuavg_pkg::ST_IDLE;
         div_ff       <= imuavg_pkg::DIV_OFF;
         count_ff     <= '0;
         fresh_ff     <= 1'b0;
         pass_ff      <= 1'b0;
         axis_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         fresh_ff     <= fresh_in;
         pass_ff      <= pass_in;
         axis_ff      <= axis_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            div_ff <= csr_wr_data;
         end
      end
      rsp_ff <= rsp_in;
      if (accept) begin
         sample_ff <= req_data;
      end
      if (state_ff == imuavg_pkg::ST_DIV_WAIT && div_done) begin
         avg_ff[axis_ff] <= quotient;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
